// File: rtl/rc4_pkg.sv
package rc4_pkg;

  // Byte and permutation table geometry.
  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;

  // Default key storage depth.
  localparam int DEF_MAX_KEY_BYTES = 256;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Kind of work an item asks for, decided by the front.
  typedef enum logic [1:0] {
    OP_KEY,
    OP_KEY_LAST,
    OP_DATA
  } op_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } item_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_KS_J,
    BK_KS_SWAP,
    BK_KS_OUT,
    BK_EMIT,
    BK_SC_READ,
    BK_SC_J,
    BK_SC_WR_K,
    BK_SC_WR_J
  } bk_state_t;

endpackage

// File: rtl/rc4_front.sv
module rc4_front
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              key_last,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_take
);

  item_t               q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_CW-1:0] fill;
  item_t               new_item;
  logic                push;
  logic                pop;

  // Classify the incoming transaction.
  always_comb begin
    new_item.data = in_byte;
    if (mode) begin
      new_item.op = OP_DATA;
    end else if (key_last) begin
      new_item.op = OP_KEY_LAST;
    end else begin
      new_item.op = OP_KEY;
    end
  end

  assign in_stall = (fill == QUEUE_CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign pop      = q_valid && q_take;
  assign q_item   = q_mem[rptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= new_item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + QUEUE_CW'(1);
      end else if (pop && !push) begin
        fill <= fill - QUEUE_CW'(1);
      end
    end
  end

endmodule

// File: rtl/rc4_back.sv
module rc4_back
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_take,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  input  logic              out_stall
);

  localparam int CW  = $clog2(MAX_KEY_BYTES + 1);
  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  bk_state_t state;
  bk_state_t state_next;

  // Permutation memory with a valid bit per entry; an invalid entry reads as its index.
  logic [BYTE_W-1:0]  perm_mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] perm_vld;
  logic [PERM_AW-1:0] rd_addr;
  logic [PERM_AW-1:0] rd_addr_q;
  logic [BYTE_W-1:0]  rd_data_q;
  logic               rd_vld_q;
  logic [BYTE_W-1:0]  perm_rd;
  logic               wr_en;
  logic [PERM_AW-1:0] wr_addr;
  logic [BYTE_W-1:0]  wr_data;
  logic               perm_clr;

  // Key memory.
  logic [BYTE_W-1:0] key_mem [MAX_KEY_BYTES];
  logic              key_wr_en;
  logic [KAW-1:0]    key_rd_addr;
  logic [BYTE_W-1:0] key_q;

  // Cipher state and working registers.
  logic [PERM_AW-1:0] idx_i;
  logic [PERM_AW-1:0] idx_j;
  logic [CW-1:0]      key_count;
  logic [CW-1:0]      count_after;
  logic [CW-1:0]      sched_len;
  logic [PERM_AW-1:0] kk;
  logic [KAW-1:0]     kidx;
  logic [BYTE_W-1:0]  s_a;
  logic [BYTE_W-1:0]  s_b;
  logic [PERM_AW-1:0] t_addr;
  logic [BYTE_W-1:0]  dbyte;
  logic [BYTE_W-1:0]  res;
  logic [BYTE_W-1:0]  ks;
  logic [BYTE_W-1:0]  result;
  logic               out_free;
  logic               key_room;

  assign perm_rd     = rd_vld_q ? rd_data_q : rd_addr_q;
  assign out_free    = !out_valid || !out_stall;
  assign key_room    = (key_count < CW'(MAX_KEY_BYTES));
  assign count_after = key_room ? key_count + CW'(1) : key_count;

  // Keystream byte after the swap: the two swapped entries come from the registers.
  always_comb begin
    if (t_addr == idx_j) begin
      ks = s_a;
    end else if (t_addr == idx_i) begin
      ks = s_b;
    end else begin
      ks = perm_rd;
    end
  end
  assign result = dbyte ^ ks;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_DATA:     state_next = BK_KS_J;
            OP_KEY_LAST: state_next = BK_SC_READ;
            default:     state_next = BK_IDLE;
          endcase
        end
      end
      BK_KS_J:    state_next = BK_KS_SWAP;
      BK_KS_SWAP: state_next = BK_KS_OUT;
      BK_KS_OUT:  state_next = out_free ? BK_IDLE : BK_EMIT;
      BK_EMIT:    state_next = out_free ? BK_IDLE : BK_EMIT;
      BK_SC_READ: state_next = BK_SC_J;
      BK_SC_J:    state_next = BK_SC_WR_K;
      BK_SC_WR_K: state_next = BK_SC_WR_J;
      BK_SC_WR_J: state_next = (kk == PERM_AW'(PERM_DEPTH - 1)) ? BK_IDLE : BK_SC_READ;
      default:    state_next = BK_IDLE;
    endcase
  end

  // Memory controls per state.
  always_comb begin
    q_take      = 1'b0;
    rd_addr     = idx_i + PERM_AW'(1);
    wr_en       = 1'b0;
    wr_addr     = idx_i;
    wr_data     = perm_rd;
    perm_clr    = 1'b0;
    key_wr_en   = 1'b0;
    key_rd_addr = kidx;
    case (state)
      BK_IDLE: begin
        q_take    = q_valid;
        key_wr_en = q_valid && (q_item.op != OP_DATA) && key_room;
        perm_clr  = q_valid && (q_item.op == OP_KEY_LAST);
      end
      BK_KS_J: begin
        rd_addr = idx_j + perm_rd;
      end
      BK_KS_SWAP: begin
        wr_en   = 1'b1;
        wr_addr = idx_i;
        wr_data = perm_rd;
        rd_addr = s_a + perm_rd;
      end
      BK_KS_OUT: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = s_a;
      end
      BK_SC_READ: begin
        rd_addr = kk;
      end
      BK_SC_J: begin
        rd_addr = idx_j + perm_rd + key_q;
      end
      BK_SC_WR_K: begin
        wr_en   = 1'b1;
        wr_addr = kk;
        wr_data = perm_rd;
      end
      BK_SC_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = s_a;
      end
      default: begin
        q_take = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Permutation memory array with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= perm_mem[rd_addr];
    rd_vld_q  <= perm_vld[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // Entry valid bits; clearing all of them restores the identity permutation.
  always_ff @(posedge clk) begin
    if (rst || perm_clr) begin
      perm_vld <= '0;
    end else if (wr_en) begin
      perm_vld[wr_addr] <= 1'b1;
    end
  end

  // Key memory with registered read.
  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[key_count[KAW-1:0]] <= q_item.data;
    end
    key_q <= key_mem[key_rd_addr];
  end

  // Indices and key bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i     <= '0;
      idx_j     <= '0;
      key_count <= '0;
      sched_len <= '0;
      kk        <= '0;
      kidx      <= '0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (q_valid) begin
            if (q_item.op == OP_DATA) begin
              idx_i <= idx_i + PERM_AW'(1);
            end else if (q_item.op == OP_KEY_LAST) begin
              sched_len <= count_after;
              key_count <= '0;
              idx_j     <= '0;
              kk        <= '0;
              kidx      <= '0;
            end else begin
              key_count <= count_after;
            end
          end
        end
        BK_KS_J: begin
          idx_j <= idx_j + perm_rd;
        end
        BK_SC_J: begin
          idx_j <= idx_j + perm_rd + key_q;
        end
        BK_SC_WR_J: begin
          kk <= kk + PERM_AW'(1);
          if (CW'(kidx) + CW'(1) >= sched_len) begin
            kidx <= '0;
          end else begin
            kidx <= kidx + KAW'(1);
          end
          if (kk == PERM_AW'(PERM_DEPTH - 1)) begin
            idx_i <= '0;
            idx_j <= '0;
          end
        end
        default: begin
          kk <= kk;
        end
      endcase
    end
  end

  // Working registers of the swap and output steps.
  always_ff @(posedge clk) begin
    if ((state == BK_IDLE) && q_valid) begin
      dbyte <= q_item.data;
    end
    if ((state == BK_KS_J) || (state == BK_SC_J)) begin
      s_a <= perm_rd;
    end
    if (state == BK_KS_SWAP) begin
      s_b    <= perm_rd;
      t_addr <= s_a + perm_rd;
    end
    if ((state == BK_KS_OUT) && !out_free) begin
      res <= result;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == BK_KS_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if ((state == BK_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == BK_KS_OUT) && out_free) begin
      out_byte <= result;
    end else if ((state == BK_EMIT) && out_free) begin
      out_byte <= res;
    end
  end

endmodule

// File: rtl/rc4_stream_cipher_unit.sv
// RC4 stream cipher. Key bytes (mode 0) are stored in order, up to MAX_KEY_BYTES of
// them, one per cycle while the back end is idle; the key byte flagged key_last
// then runs the key schedule, 256 swap steps through BK_SC_READ, BK_SC_J,
// BK_SC_WR_K and BK_SC_WR_J each, and yields no transaction on the output. Each
// data byte (mode 1) gives one output transaction holding the byte XORed with the
// next keystream byte, registered out after the back end takes it from the queue
// and steps through BK_KS_J, BK_KS_SWAP and BK_KS_OUT (and BK_EMIT while the output
// stalls); no new item is taken before BK_IDLE. The steps are set by the one-read,
// one-write permutation memory: every swap step needs dependent reads and two
// writes. A two-entry queue sits in front of the engine and an output register
// behind it, so up to two transactions are still accepted while the engine is busy
// or a result waits. Before any key is scheduled the identity permutation is used.
module rc4_stream_cipher_unit
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              key_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte
);

  logic  q_valid;
  item_t q_item;
  logic  q_take;

  // Front end: accepts and classifies transactions into the queue.
  rc4_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .in_byte  (in_byte),
    .key_last (key_last),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  // Back end: key storage, key schedule and keystream generation.
  rc4_back #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_stall (out_stall)
  );

endmodule
